// ===== hw/rtl/btok_pkg.sv =====
// shared types and constants of the byte stream tokenizer
package btok_pkg;

  localparam int unsigned MaxTokenLen = 100;
  localparam int unsigned LenW = $clog2(MaxTokenLen);
  localparam int unsigned KwLen = 4;
  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] KwText [KwLen] = '{8'h65, 8'h78, 8'h69, 8'h74};

  typedef enum logic [2:0] {
    TT_EOI     = 3'd0,
    TT_IDENT   = 3'd1,
    TT_KEYWORD = 3'd2,
    TT_NUMBER  = 3'd3,
    TT_SYMBOL  = 3'd4
  } tok_type_e;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } scan_mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_value;
    logic [2:0] token_type;
    logic [6:0] token_length;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] items;
    logic [1:0]        count;
  } cmd_t;

endpackage

// ===== hw/rtl/btok_if.sv =====
// handshake channels of the byte stream tokenizer
interface btok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface btok_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_value;
  logic [2:0] token_type;
  logic [6:0] token_length;
  logic       last;

  modport source (output valid, output kind, output char_value, output token_type,
                  output token_length, output last, input ready);
  modport sink   (input valid, input kind, input char_value, input token_type,
                  input token_length, input last, output ready);
endinterface

// ===== hw/rtl/btok_front.sv =====
// front part: accepts and classifies bytes, keeps scanner state, builds result lists
module btok_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output btok_pkg::cmd_t    cmd_o
);

  btok_pkg::scan_mode_e          mode_q, mode_d;
  logic [btok_pkg::LenW-1:0]     len_q, len_d;
  logic [2:0]                    prog_q, prog_d;
  logic                          miss_q, miss_d;

  btok_pkg::res_t [btok_pkg::MaxRes-1:0] res;
  logic [1:0] n;
  logic       is_ws, is_letter, is_digit, extend, do_add, accept;

  function automatic btok_pkg::res_t close_item(btok_pkg::scan_mode_e mode,
                                                logic [2:0] prog, logic miss,
                                                logic [btok_pkg::LenW-1:0] len);
    btok_pkg::res_t r;
    r = '0;
    r.kind = 1'b1;
    if (mode == btok_pkg::MODE_IDENT) begin
      r.token_type = (!miss && prog == 3'd4) ? btok_pkg::TT_KEYWORD : btok_pkg::TT_IDENT;
    end else begin
      r.token_type = btok_pkg::TT_NUMBER;
    end
    r.token_length = 7'(len);
    return r;
  endfunction

  assign is_ws     = (char_code_i == 8'd32) || (char_code_i >= 8'd9 && char_code_i <= 8'd13);
  assign is_letter = (char_code_i >= 8'd65 && char_code_i <= 8'd90) ||
                     (char_code_i >= 8'd97 && char_code_i <= 8'd122);
  assign is_digit  = (char_code_i >= 8'd48 && char_code_i <= 8'd57);
  assign extend    = (mode_q == btok_pkg::MODE_IDENT && (is_letter || is_digit)) ||
                     (mode_q == btok_pkg::MODE_NUMBER && is_digit);

  always_comb begin
    res    = '0;
    n      = 2'd0;
    mode_d = mode_q;
    len_d  = len_q;
    prog_d = prog_q;
    miss_d = miss_q;
    do_add = 1'b0;
    if (extend) begin
      do_add = 1'b1;
    end else begin
      if (mode_q != btok_pkg::MODE_IDLE) begin
        res[n] = close_item(mode_q, prog_q, miss_q, len_q);
        n      = n + 2'd1;
      end
      mode_d = btok_pkg::MODE_IDLE;
      len_d  = '0;
      prog_d = 3'd0;
      miss_d = 1'b0;
      if (is_ws) begin
        do_add = 1'b0;
      end else if (char_code_i == 8'd0) begin
        res[n].kind       = 1'b1;
        res[n].token_type = btok_pkg::TT_EOI;
        n                 = n + 2'd1;
      end else if (is_letter) begin
        mode_d = btok_pkg::MODE_IDENT;
        do_add = 1'b1;
      end else if (is_digit) begin
        mode_d = btok_pkg::MODE_NUMBER;
        do_add = 1'b1;
      end else begin
        res[n].char_value = char_code_i;
        n                 = n + 2'd1;
        res[n].kind         = 1'b1;
        res[n].token_type   = btok_pkg::TT_SYMBOL;
        res[n].token_length = 7'd1;
        n                   = n + 2'd1;
      end
    end
    if (do_add) begin
      if (mode_d == btok_pkg::MODE_IDENT) begin
        if (!miss_d && len_d < btok_pkg::LenW'(btok_pkg::KwLen) &&
            char_code_i == btok_pkg::KwText[len_d[1:0]]) begin
          prog_d = prog_d + 3'd1;
        end else begin
          miss_d = 1'b1;
        end
      end
      len_d             = len_d + btok_pkg::LenW'(1);
      res[n].char_value = char_code_i;
      n                 = n + 2'd1;
      if (len_d >= btok_pkg::LenW'(btok_pkg::MaxTokenLen - 1)) begin
        res[n] = close_item(mode_d, prog_d, miss_d, len_d);
        n      = n + 2'd1;
        mode_d = btok_pkg::MODE_IDLE;
        len_d  = '0;
        prog_d = 3'd0;
        miss_d = 1'b0;
      end
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = in_valid_i && (n != 2'd0);
  assign cmd_o.items = res;
  assign cmd_o.count = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= btok_pkg::MODE_IDLE;
      len_q  <= '0;
      prog_q <= 3'd0;
      miss_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      prog_q <= prog_d;
      miss_q <= miss_d;
    end
  end

endmodule

// ===== hw/rtl/btok_back.sv =====
// back part: two-entry queue of result lists and result serializer
module btok_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  btok_pkg::cmd_t    cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output btok_pkg::res_t    res_o
);

  btok_pkg::cmd_t queue_q [2];
  logic [1:0]     count_q;
  logic           wr_q, rd_q;
  logic [1:0]     sub_q;
  logic           push, pop, fire;
  btok_pkg::cmd_t head;

  assign head        = queue_q[rd_q];
  assign cmd_ready_o = (count_q != 2'd2);
  assign push        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = (count_q != 2'd0);
  assign fire        = out_valid_o && out_ready_i;
  assign pop         = fire && (sub_q == head.count - 2'd1);
  assign res_o       = head.items[sub_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      sub_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q  <= ~rd_q;
        sub_q <= 2'd0;
      end else if (fire) begin
        sub_q <= sub_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/byte_stream_tokenizer.sv =====
// top level of the byte stream tokenizer
//
// in_i carries one source byte per item (char_code); 0 marks end of input.
// out_o carries result items: token characters (kind 0, char_value) and
// token ends (kind 1, token_type, token_length); last marks the final
// result caused by an input byte. Whitespace gives no result of its own.
// A byte causes zero to three results. The front classifies the byte and
// updates the scanner state in the cycle it is accepted, then hands its
// result list to a two-entry queue, which registers it; the back then shows
// the list's results on out_o in order. The back drains the queue at one
// result per cycle while out_o.ready is high, so throughput is set by the
// result port; a byte that closes a token and then forms a symbol gives
// three results and takes the longest to drain.
// A stalled receiver fills the queue; in_i.ready drops once both entries
// hold pending lists, and nothing is lost or repeated.
// Reset empties the queue and returns the scanner to idle with no open
// token; no clearing pass is needed.
module byte_stream_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  btok_in_if.sink    in_i,
  btok_out_if.source out_o
);

  logic           cmd_valid, cmd_ready;
  btok_pkg::cmd_t cmd;
  btok_pkg::res_t res;

  btok_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .char_code_i (in_i.char_code),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  btok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.kind         = res.kind;
  assign out_o.char_value   = res.char_value;
  assign out_o.token_type   = res.token_type;
  assign out_o.token_length = res.token_length;
  assign out_o.last         = res.last;

`ifndef SYNTHESIS
  a_eoi_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind && out_o.token_type == btok_pkg::TT_EOI
    |-> out_o.token_length == 7'd0)
    else $error("end of input token with nonzero length");

  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.kind
    |-> out_o.token_type == 3'd0 && out_o.token_length == 7'd0 && out_o.char_value != 8'd0)
    else $error("bad token character item");

  a_symbol_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind && out_o.token_type == btok_pkg::TT_SYMBOL
    |-> out_o.token_length == 7'd1 && out_o.last)
    else $error("bad symbol token end");
`endif

endmodule
